FILE: sv/mcg_pkg.sv
// ----------------------------------------------------------------------------
// mcg_pkg: shared types and constants for the month calendar grid unit
// Month length tables, calendar constants and the narrow types used by the
// sequencer, the mod-25 reducer and the weekday adder.
// ----------------------------------------------------------------------------
package mcg_pkg;

   typedef logic [2:0] wday_type;
   typedef logic [4:0] day_type;
   typedef logic [3:0] month_type;
   typedef logic [4:0] res25_type;

   localparam int        EPOCH_YEAR     = 1900;
   localparam wday_type  EPOCH_WEEKDAY  = 3'd1;
   localparam wday_type  DAYS_PER_WEEK  = 3'd7;
   localparam wday_type  LAST_WEEKDAY   = 3'd6;
   localparam int        CENTURY_FACTOR = 25;
   localparam month_type MONTH_JAN      = 4'd1;
   localparam month_type MONTH_FEB      = 4'd2;
   localparam month_type MONTH_DEC      = 4'd12;
   localparam day_type   FEB_DAYS       = 5'd28;

   // Days in month m; February gets one more in a leap year.
   function automatic day_type month_len(input month_type m, input logic leap);
      day_type n;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         MONTH_FEB:                                  n = FEB_DAYS + day_type'(leap);
         default:                                    n = 5'd0;
      endcase
      return n;
   endfunction

   // Month length reduced modulo 7, as a small table.
   function automatic wday_type len_mod7(input month_type m, input logic leap);
      wday_type r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 3'd3;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 3'd2;
         MONTH_FEB:                                  r = wday_type'(leap);
         default:                                    r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/mcg_mod25.sv
// ----------------------------------------------------------------------------
// mcg_mod25: residue of the year modulo 25 by reciprocal multiplication
// Latches the year, forms the quotient by 25 with a constant multiply and
// shift, then the remainder with a shift-and-add and a subtract. The residue
// is valid once done is high again after load.
// ----------------------------------------------------------------------------
module mcg_mod25 #(
   parameter int YEAR_WIDTH = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [YEAR_WIDTH-1:0]  year,
   output logic                   done,
   output mcg_pkg::res25_type     residue
);
   import mcg_pkg::*;

   // The product shifted down by RECIP_SHIFT gives the exact quotient by 25
   // for every year below 2**16.
   localparam int          RECIP_SHIFT = 21;
   localparam int          RECIP_BITS  = 17;
   localparam logic [16:0] RECIP_25    = 17'd83887;
   localparam int          PW          = YEAR_WIDTH + RECIP_BITS;
   localparam int          QW          = PW - RECIP_SHIFT;

   logic [YEAR_WIDTH-1:0] year_ff, year_in;
   logic [QW-1:0]         quot_ff, quot_in;
   res25_type             rem_ff, rem_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [PW-1:0]         prod;
   logic [YEAR_WIDTH-1:0] quot_ext;
   logic [YEAR_WIDTH-1:0] times25;

   // The quotient is registered first, then the remainder from it.
   always_comb begin
      prod     = PW'(year_ff) * PW'(RECIP_25);
      quot_ext = YEAR_WIDTH'(quot_ff);
      times25  = (quot_ext << 4) + (quot_ext << 3) + quot_ext;
      year_in  = year_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         year_in = year;
         cnt_in  = 2'd2;
      end else if (cnt_ff != '0) begin
         quot_in = prod[PW-1:RECIP_SHIFT];
         rem_in  = 5'(year_ff - times25);
         cnt_in  = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      year_ff <= year_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done    = (cnt_ff == '0);
   assign residue = rem_ff;

endmodule

FILE: sv/mcg_wadd.sv
// ----------------------------------------------------------------------------
// mcg_wadd: weekday adder modulo 7
// Adds two weekday values, each below 7, and folds the sum back below 7.
// ----------------------------------------------------------------------------
module mcg_wadd (
   input  mcg_pkg::wday_type a,
   input  mcg_pkg::wday_type b,
   output mcg_pkg::wday_type sum
);
   import mcg_pkg::*;

   logic [3:0] raw;

   always_comb begin
      raw = {1'b0, a} + {1'b0, b};
      sum = (raw >= {1'b0, DAYS_PER_WEEK}) ? 3'(raw - {1'b0, DAYS_PER_WEEK}) : 3'(raw);
   end

endmodule

FILE: sv/month_calendar_grid_unit.sv
// ----------------------------------------------------------------------------
// month_calendar_grid_unit: Sunday-first calendar grid for one month
// Finds the weekday of the month's first day and emits one item per day.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; for a month from one
// to twelve, busy then stays high until the last day has been sent. The
// year's residue modulo 25 for the leap rule is found first, then every year
// from 1900 up to the given one is added through the shared modulo-7 weekday
// adder, one year per cycle, which dominates; years up to 1900 add none. The
// earlier months follow at one per cycle, and then the days are sent one per
// cycle on rsp_strobe with no gaps. The receiver cannot stall, so each result
// is valid for one cycle only. A month of zero or above twelve is taken and
// gives no results.
module month_calendar_grid_unit #(
   parameter int YEAR_WIDTH = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [YEAR_WIDTH-1:0] req_year,
   input  mcg_pkg::month_type    req_month,
   output logic                  rsp_strobe,
   output mcg_pkg::day_type      rsp_day,
   output mcg_pkg::wday_type     rsp_weekday,
   output logic [2:0]            rsp_week_row,
   output logic                  rsp_last
);
   import mcg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD25,
      ST_YEARS,
      ST_MONTHS,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [YEAR_WIDTH-1:0] year_ff;
   month_type             month_ff;
   logic [YEAR_WIDTH-1:0] run_year_ff;
   res25_type             run25_ff;
   wday_type              w_ff;
   month_type             k_ff;
   logic                  leap_ff;
   day_type               len_ff;
   day_type               day_ff;
   wday_type              col_ff;
   logic [2:0]            row_ff;

   logic                  strobe_ff;
   day_type               out_day_ff;
   wday_type              out_wday_ff;
   logic [2:0]            out_row_ff;
   logic                  out_last_ff;

   logic                  accept;
   logic                  m25_done;
   res25_type             m25_res;
   logic                  target_leap;
   logic                  run_leap;
   wday_type              add_a, add_b, add_sum;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   mcg_mod25 #(.YEAR_WIDTH(YEAR_WIDTH)) u_mod25 (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .year    (req_year),
      .done    (m25_done),
      .residue (m25_res)
   );

   // Divisible by 4 and not by 100, or by 400 (that is, by 16 and by 25).
   always_comb begin
      target_leap = (year_ff[1:0] == 2'b00) && ((m25_res != '0) || (year_ff[3:0] == 4'b0000));
      run_leap    = (run_year_ff[1:0] == 2'b00) &&
                    ((run25_ff != '0) || (run_year_ff[3:0] == 4'b0000));
   end

   // The one weekday adder is shared by the year walk, the month walk and the
   // column count.
   always_comb begin
      case (state_ff)
         ST_YEARS: begin
            add_a = w_ff;
            add_b = run_leap ? 3'd2 : 3'd1;
         end
         ST_MONTHS: begin
            add_a = w_ff;
            add_b = len_mod7(k_ff, leap_ff);
         end
         ST_EMIT: begin
            add_a = col_ff;
            add_b = 3'd1;
         end
         default: begin
            add_a = '0;
            add_b = '0;
         end
      endcase
   end

   mcg_wadd u_wadd (
      .a   (add_a),
      .b   (add_b),
      .sum (add_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_month >= MONTH_JAN) && (req_month <= MONTH_DEC)) begin
                  state_ff <= ST_MOD25;
               end
            end
            ST_MOD25: begin
               if (m25_done) begin
                  state_ff <= (year_ff > YEAR_WIDTH'(EPOCH_YEAR)) ? ST_YEARS : ST_MONTHS;
               end
            end
            ST_YEARS: begin
               if (run_year_ff + 1'b1 == year_ff) begin
                  state_ff <= ST_MONTHS;
               end
            end
            ST_MONTHS: begin
               if (k_ff == month_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               strobe_ff <= 1'b1;
               if (day_ff == len_ff) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               year_ff     <= req_year;
               month_ff    <= req_month;
               run_year_ff <= YEAR_WIDTH'(EPOCH_YEAR);
               run25_ff    <= '0;
               w_ff        <= EPOCH_WEEKDAY;
               k_ff        <= MONTH_JAN;
            end
         end
         ST_MOD25: begin
            leap_ff <= target_leap;
            len_ff  <= month_len(month_ff, target_leap);
         end
         ST_YEARS: begin
            w_ff        <= add_sum;
            run_year_ff <= run_year_ff + 1'b1;
            run25_ff    <= (run25_ff == res25_type'(CENTURY_FACTOR - 1)) ? '0
                                                                         : run25_ff + 1'b1;
         end
         ST_MONTHS: begin
            if (k_ff == month_ff) begin
               day_ff <= 5'd1;
               col_ff <= w_ff;
               row_ff <= '0;
            end else begin
               w_ff <= add_sum;
               k_ff <= k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            out_day_ff  <= day_ff;
            out_wday_ff <= col_ff;
            out_row_ff  <= row_ff;
            out_last_ff <= (day_ff == len_ff);
            day_ff      <= day_ff + 1'b1;
            col_ff      <= add_sum;
            if (col_ff == LAST_WEEKDAY) begin
               row_ff <= row_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_day      = out_day_ff;
   assign rsp_weekday  = out_wday_ff;
   assign rsp_week_row = out_row_ff;
   assign rsp_last     = out_last_ff;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for month_calendar_grid_unit
// Offers year/month items, first from a directed table and then at random,
// predicts every calendar cell of the month and checks each strobed result
// in order, under several patterns of sender idling.
// ----------------------------------------------------------------------------
module tb;
   import mcg_pkg::*;

   localparam int YEAR_BITS     = 12;
   localparam int RANDOM_ITEMS  = 207;
   localparam int DRAIN_CYCLES  = 2400;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int NUM_DIRECTED  = 23;
   localparam int BAD_MONTH     = 0;

   typedef struct packed {
      day_type    day;
      wday_type   weekday;
      logic [2:0] row;
      logic       last;
   } grid_cell_type;

   // A row with known set carries the weekday of day 1 and the month length.
   typedef struct packed {
      logic [YEAR_BITS-1:0] year;
      month_type            month;
      logic                 known;
      wday_type             first;
      logic [5:0]           ndays;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [YEAR_BITS-1:0] req_year = '0;
   month_type            req_month = '0;
   logic                 busy;
   logic                 rsp_strobe;
   day_type              rsp_day;
   wday_type             rsp_weekday;
   logic [2:0]           rsp_week_row;
   logic                 rsp_last;

   grid_cell_type pending_cells[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{12'd1900, 4'd1,  1'b1, 3'd1, 6'd31},
      '{12'd1900, 4'd2,  1'b1, 3'd4, 6'd28},
      '{12'd1900, 4'd9,  1'b1, 3'd6, 6'd30},
      '{12'd1900, 4'd12, 1'b0, 3'd0, 6'd0},
      '{12'd1901, 4'd1,  1'b1, 3'd2, 6'd31},
      '{12'd2000, 4'd1,  1'b1, 3'd6, 6'd31},
      '{12'd2000, 4'd2,  1'b1, 3'd2, 6'd29},
      '{12'd2100, 4'd2,  1'b0, 3'd0, 6'd0},
      '{12'd2400, 4'd2,  1'b0, 3'd0, 6'd0},
      '{12'd2024, 4'd2,  1'b0, 3'd0, 6'd0},
      '{12'd1904, 4'd3,  1'b0, 3'd0, 6'd0},
      '{12'd2048, 4'd7,  1'b0, 3'd0, 6'd0},
      '{12'd3071, 4'd4,  1'b0, 3'd0, 6'd0},
      '{12'd4095, 4'd1,  1'b0, 3'd0, 6'd0},
      '{12'd4095, 4'd2,  1'b0, 3'd0, 6'd0},
      '{12'd4095, 4'd12, 1'b0, 3'd0, 6'd0},
      '{12'd0,    4'd1,  1'b1, 3'd1, 6'd31},
      '{12'd0,    4'd2,  1'b1, 3'd4, 6'd29},
      '{12'd1899, 4'd3,  1'b1, 3'd4, 6'd31},
      '{12'd1899, 4'd12, 1'b0, 3'd0, 6'd0},
      '{12'd1900, 4'd0,  1'b1, 3'd0, 6'd0},
      '{12'd2024, 4'd13, 1'b1, 3'd0, 6'd0},
      '{12'd4095, 4'd15, 1'b1, 3'd0, 6'd0}
   };

   month_calendar_grid_unit #(
      .YEAR_WIDTH(YEAR_BITS)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_year     (req_year),
      .req_month    (req_month),
      .rsp_strobe   (rsp_strobe),
      .rsp_day      (rsp_day),
      .rsp_weekday  (rsp_weekday),
      .rsp_week_row (rsp_week_row),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit is_leap(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
      int unsigned base [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) begin
         return 0;
      end
      return base[m-1] + ((m == 2 && is_leap(y)) ? 1 : 0);
   endfunction

   // Column of day 1, walking year by year from Monday, 1 January 1900.
   // Years before the epoch start the walk at that Monday directly.
   function automatic int unsigned start_column(input int unsigned y, input int unsigned m);
      int unsigned w;
      w = int'(EPOCH_WEEKDAY);
      for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) begin
         w = (w + (is_leap(yy) ? 366 : 365)) % 7;
      end
      for (int unsigned k = 1; k < m && k <= 12; k++) begin
         w = (w + days_in(y, k)) % 7;
      end
      return w;
   endfunction

   task automatic queue_month_cells(input int unsigned first, input int unsigned ndays);
      int unsigned slot;
      for (int unsigned d = 1; d <= ndays; d++) begin
         slot = first + d - 1;
         pending_cells.push_back('{day: day_type'(d), weekday: wday_type'(slot % 7),
                                   row: 3'(slot / 7), last: (d == ndays)});
      end
   endtask

   // Holds start high with the item until it is taken at a clock edge with
   // busy low. Returns at that edge.
   task automatic offer_item(input logic [YEAR_BITS-1:0] y, input month_type m,
                             input int idle_pct);
      int gap;
      gap = 0;
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         req_year <= YEAR_BITS'($urandom);
         req_month <= month_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_year <= y;
      req_month <= m;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin : cell_checker
      grid_cell_type exp_cell;
      if (!reset && rsp_strobe) begin
         if (pending_cells.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: day %0d, weekday %0d", $time, rsp_day,
                     rsp_weekday);
         end else begin
            exp_cell = pending_cells.pop_front();
            check_field("day", 8'(exp_cell.day), 8'(rsp_day));
            check_field("weekday", 8'(exp_cell.weekday), 8'(rsp_weekday));
            check_field("week_row", 8'(exp_cell.row), 8'(rsp_week_row));
            check_field("last", 8'(exp_cell.last), 8'(rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [YEAR_BITS-1:0] y;
      month_type            m;
      int                   pick;
      int                   idle_pct;
      int                   phase;
      int unsigned          bad_months [4] = '{BAD_MONTH, 13, 14, 15};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         offer_item(directed_rows[i].year, directed_rows[i].month, 0);
         if (directed_rows[i].known) begin
            queue_month_cells(directed_rows[i].first, directed_rows[i].ndays);
         end else begin
            queue_month_cells(start_column(directed_rows[i].year, directed_rows[i].month),
                              days_in(directed_rows[i].year, directed_rows[i].month));
         end
      end

      // Most years sit close to the epoch to keep the walk short; a few reach
      // the top of the range, century years hit the leap exceptions, and a
      // rare one falls below the epoch.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         phase = (i * 4) / RANDOM_ITEMS;
         case (phase)
            1:       idle_pct = 47;
            3:       idle_pct = 20;
            default: idle_pct = 0;
         endcase
         pick = $urandom_range(99);
         if (pick < 62) begin
            y = YEAR_BITS'(EPOCH_YEAR + $urandom_range(0, 150));
         end else if (pick < 74) begin
            y = YEAR_BITS'(100 * $urandom_range(19, 40));
         end else if (pick < 88) begin
            y = YEAR_BITS'($urandom_range(EPOCH_YEAR, 2600));
         end else if (pick < 97) begin
            y = YEAR_BITS'($urandom_range(EPOCH_YEAR, 4095));
         end else begin
            y = YEAR_BITS'($urandom_range(0, EPOCH_YEAR - 1));
         end
         if ($urandom_range(99) < 5) begin
            m = month_type'(bad_months[$urandom_range(3)]);
         end else if (pick >= 62 && pick < 74 && $urandom_range(1) == 1) begin
            m = MONTH_FEB;
         end else begin
            m = month_type'($urandom_range(MONTH_JAN, MONTH_DEC));
         end
         offer_item(y, m, idle_pct);
         queue_month_cells(start_column(y, m), days_in(y, m));
      end

      start <= 1'b0;
      while (pending_cells.size() != 0 || busy) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_cells.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: month_calendar_grid_unit.f
sv/mcg_pkg.sv
sv/mcg_mod25.sv
sv/mcg_wadd.sv
sv/month_calendar_grid_unit.sv
tb/tb.sv
